FILE: rtl/erbp_pkg.sv
// shared types and constants of the ellipse ray boundary point block
package erbp_pkg;

   localparam int TRIG_WIDTH      = 16;
   localparam int AXIS_WIDTH      = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COS_THETA   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SIN_THETA   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SEMI_AXIS_X = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SEMI_AXIS_Y = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CENTER_X    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CENTER_Y    = 3'd5;

   localparam logic [TRIG_WIDTH-1:0] COS_RESET  = 16'd16384;
   localparam logic [TRIG_WIDTH-1:0] SIN_RESET  = 16'd0;
   localparam logic [AXIS_WIDTH-1:0] AXIS_RESET = 24'd256;

   // the larger normalized magnitude lies in [2^30, 2^31)
   localparam int NORM_WIDTH  = 31;
   localparam int SQ_WIDTH    = 2 * NORM_WIDTH;
   localparam int RAD_WIDTH   = 64;
   localparam int ROOT_WIDTH  = 32;
   localparam int QUOT_WIDTH  = 31;
   localparam int NUM_WIDTH   = 62;
   localparam int FRAC_SHIFT  = 30;
   localparam int ROT_SHIFT   = 14;

   typedef struct packed {
      logic invalid;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

FILE: rtl/erbp_isqrt.sv
// pipelined integer square root, one result bit per stage
module erbp_isqrt (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [erbp_pkg::RAD_WIDTH-1:0]     radicand,
   output logic [erbp_pkg::ROOT_WIDTH-1:0]    root
);
   import erbp_pkg::*;

   localparam int REM_WIDTH = ROOT_WIDTH + 4;

   logic [REM_WIDTH-1:0]  rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];
   logic [RAD_WIDTH-1:0]  rad_ff  [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      localparam int BIT = ROOT_WIDTH - 1 - k;
      logic [REM_WIDTH-1:0]  prev_rem;
      logic [ROOT_WIDTH-1:0] prev_root;
      logic [RAD_WIDTH-1:0]  prev_rad;
      logic [REM_WIDTH-1:0]  rem_shift;
      logic [REM_WIDTH-1:0]  trial;
      logic [REM_WIDTH-1:0]  rem_in;
      logic [ROOT_WIDTH-1:0] root_in;

      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_rad  = radicand;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_rad  = rad_ff[k-1];
      end

      always_comb begin
         rem_shift = {prev_rem[REM_WIDTH-3:0], prev_rad[2*BIT+1 -: 2]};
         trial     = {(REM_WIDTH-2)'(prev_root), 2'b01};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {prev_root[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {prev_root[ROOT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= prev_rad;
         end
      end
   end

   assign root = root_ff[ROOT_WIDTH-1];

endmodule

FILE: rtl/erbp_div.sv
// pipelined restoring divider, one quotient bit per stage
module erbp_div (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [erbp_pkg::NUM_WIDTH-1:0]     numerator,
   input  logic [erbp_pkg::ROOT_WIDTH-1:0]    denominator,
   output logic [erbp_pkg::QUOT_WIDTH-1:0]    quotient
);
   import erbp_pkg::*;

   // quotient is known to stay below 2^QUOT_WIDTH
   logic [ROOT_WIDTH-1:0] rem_ff [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] quo_ff [QUOT_WIDTH];
   logic [NUM_WIDTH-1:0]  num_ff [QUOT_WIDTH];
   logic [ROOT_WIDTH-1:0] den_ff [QUOT_WIDTH];

   for (genvar k = 0; k < QUOT_WIDTH; k++) begin : g_stage
      localparam int BIT = QUOT_WIDTH - 1 - k;
      logic [ROOT_WIDTH-1:0] prev_rem;
      logic [QUOT_WIDTH-1:0] prev_quo;
      logic [NUM_WIDTH-1:0]  prev_num;
      logic [ROOT_WIDTH-1:0] prev_den;
      logic [ROOT_WIDTH:0]   rem_shift;
      logic [ROOT_WIDTH-1:0] rem_in;
      logic [QUOT_WIDTH-1:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_rem = ROOT_WIDTH'(numerator[NUM_WIDTH-1:QUOT_WIDTH]);
         assign prev_quo = '0;
         assign prev_num = numerator;
         assign prev_den = denominator;
      end else begin : g_next
         assign prev_rem = rem_ff[k-1];
         assign prev_quo = quo_ff[k-1];
         assign prev_num = num_ff[k-1];
         assign prev_den = den_ff[k-1];
      end

      always_comb begin
         rem_shift = {prev_rem, prev_num[BIT]};
         quo_in    = prev_quo;
         if (rem_shift >= {1'b0, prev_den}) begin
            rem_in      = ROOT_WIDTH'(rem_shift - {1'b0, prev_den});
            quo_in[BIT] = 1'b1;
         end else begin
            rem_in = ROOT_WIDTH'(rem_shift);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            num_ff[k] <= prev_num;
            den_ff[k] <= prev_den;
         end
      end
   end

   assign quotient = quo_ff[QUOT_WIDTH-1];

endmodule

FILE: rtl/ellipse_ray_boundary_point.sv
// ellipse ray boundary point: top level with rotation, scaling and output stages
//
// For each query point the block returns the point where the ray from the
// ellipse center through the query point crosses the ellipse boundary. The
// point is rotated into the ellipse frame, offset from the center, scaled by
// a*b/sqrt((b*x)^2+(a*y)^2) and rotated back; the coordinates saturate to the
// signed COORD_WIDTH range. A point equal to the center, or an offset that
// gives a zero denominator, returns invalid with zero coordinates. The pipeline
// takes one word per cycle, unless the result side stalls, through 75 register
// stages. The square root (32 stages, one root bit each) and the two parallel
// dividers (31 stages, one quotient bit each) make up most of them. A stall
// on the result side holds every stage in place. Configuration is written
// only while no word is in flight: the user must keep to this, the block
// itself does not enforce it.
module ellipse_ray_boundary_point #(
   parameter  int COORD_WIDTH = 24,
   localparam int DATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8,
   localparam int CSR_WIDTH   = (COORD_WIDTH > erbp_pkg::AXIS_WIDTH) ?
                                COORD_WIDTH : erbp_pkg::AXIS_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [DATA_WIDTH-1:0]                   req_tdata,  // point_x, point_y
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [DATA_WIDTH-1:0]                   rsp_tdata,  // boundary_x, boundary_y
   output logic                                    rsp_tuser,  // invalid
   input  logic                                    csr_wr_en,
   input  logic [erbp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_WIDTH-1:0]                    csr_wdata
);
   import erbp_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int PW1  = W + TRIG_WIDTH;          // forward rotation product
   localparam int SW1  = PW1 + 1;                 // forward rotation sum
   localparam int XW   = W + 4;                   // offset in ellipse frame
   localparam int UW   = XW + AXIS_WIDTH;         // scaled magnitude
   localparam int POSW = $clog2(UW);
   localparam int PW2  = W + 11;                  // boundary point before back rotation
   localparam int PP2  = PW2 + TRIG_WIDTH;
   localparam int SS2  = PP2 + 1;
   localparam int RW2  = SS2 - ROT_SHIFT;
   localparam int OXW  = AXIS_WIDTH + 1;
   localparam int OPW  = AXIS_WIDTH + QUOT_WIDTH;

   localparam logic signed [SW1-1:0] RND1    = SW1'(1 << (ROT_SHIFT - 1));
   localparam logic signed [SS2-1:0] RND2    = SS2'(1 << (ROT_SHIFT - 1));
   localparam logic [OPW-1:0]        RND_OUT = OPW'(1 << (FRAC_SHIFT - 1));
   localparam logic signed [RW2-1:0] SAT_HI  = RW2'((longint'(1) << (W - 1)) - 1);
   localparam logic signed [RW2-1:0] SAT_LO  = -SAT_HI - RW2'(1);

   // configuration registers
   logic signed [TRIG_WIDTH-1:0] cos_ff, sin_ff;
   logic [AXIS_WIDTH-1:0]        axis_a_ff, axis_b_ff;
   logic signed [W-1:0]          cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= COS_RESET;
         sin_ff    <= SIN_RESET;
         axis_a_ff <= AXIS_RESET;
         axis_b_ff <= AXIS_RESET;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_COS_THETA:   cos_ff    <= csr_wdata[TRIG_WIDTH-1:0];
            REG_SIN_THETA:   sin_ff    <= csr_wdata[TRIG_WIDTH-1:0];
            REG_SEMI_AXIS_X: axis_a_ff <= csr_wdata[AXIS_WIDTH-1:0];
            REG_SEMI_AXIS_Y: axis_b_ff <= csr_wdata[AXIS_WIDTH-1:0];
            REG_CENTER_X:    cx_ff     <= csr_wdata[W-1:0];
            REG_CENTER_Y:    cy_ff     <= csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipe moves when the output register is free or being taken
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   logic signed [W-1:0] px, py;
   assign px = req_tdata[W-1:0];
   assign py = req_tdata[2*W-1:W];

   // valid bits of the explicit stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic v40_ff, v72_ff, v73_ff, v74_ff;
   logic sq_valid_ff  [ROOT_WIDTH];
   logic div_valid_ff [QUOT_WIDTH];

   // stage 1: forward rotation products, center test
   logic signed [PW1-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic                  eq1_ff;
   // stage 2: offset in the ellipse frame
   logic signed [XW-1:0]  xx2_ff, yy2_ff;
   logic                  eq2_ff;
   logic signed [SW1-1:0] sumx2, sumy2;
   logic [XW-2:0]         rotx2, roty2;
   // stage 3: scaled magnitudes
   logic [UW-1:0]         u3_ff, v3m_ff;
   side_type              side3_ff;
   logic [XW-1:0]         magx3, magy3;
   // stage 4: leading one search
   logic [UW-1:0]         u4_ff, v4m_ff;
   logic [POSW-1:0]       pos4_ff;
   side_type              side4_ff;
   logic [UW-1:0]         max4;
   logic [POSW-1:0]       pos4_in;
   // stage 5: normalized magnitudes
   logic [NORM_WIDTH-1:0] un5_ff, vn5_ff;
   side_type              side5_ff;
   logic [NORM_WIDTH-1:0] un5_in, vn5_in;
   logic [POSW-1:0]       shr5, shl5;
   // stage 6, 7: squares and radicand
   logic [SQ_WIDTH-1:0]   usq6_ff, vsq6_ff;
   logic [NORM_WIDTH-1:0] un6_ff, vn6_ff, un7_ff, vn7_ff;
   side_type              side6_ff, side7_ff;
   logic [RAD_WIDTH-1:0]  rad7_ff;
   // square root span
   logic [ROOT_WIDTH-1:0] den;
   logic [NORM_WIDTH-1:0] un_sq_ff [ROOT_WIDTH];
   logic [NORM_WIDTH-1:0] vn_sq_ff [ROOT_WIDTH];
   side_type              side_sq_ff [ROOT_WIDTH];
   // stage 40: division operands
   logic [NUM_WIDTH-1:0]  numx40_ff, numy40_ff;
   logic [ROOT_WIDTH-1:0] den40_ff;
   side_type              side40_ff;
   // divider span
   logic [QUOT_WIDTH-1:0] rx, ry;
   side_type              side_div_ff [QUOT_WIDTH];
   // stage 72: offset magnitudes
   logic [OXW-1:0]        ox72_ff, oy72_ff;
   side_type              side72_ff;
   logic [OPW-1:0]        prodx72, prody72;
   // stage 73: boundary point in the ellipse frame
   logic signed [PW2-1:0] x73_ff, y73_ff;
   logic                  inv73_ff;
   logic signed [PW2-1:0] ofsx73, ofsy73;
   // stage 74: back rotation products
   logic signed [PP2-1:0] xc74_ff, ys74_ff, yc74_ff, xs74_ff;
   logic                  inv74_ff;
   // output register
   logic signed [W-1:0]   outx_ff, outy_ff;
   logic                  out_inv_ff;
   logic signed [SS2-1:0] sumx75, sumy75;
   logic signed [RW2-1:0] rotx75, roty75;
   logic signed [W-1:0]   satx75, saty75;

   // control: valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0; v40_ff <= 1'b0;
         v72_ff <= 1'b0; v73_ff <= 1'b0; v74_ff <= 1'b0; out_valid_ff <= 1'b0;
         for (int i = 0; i < ROOT_WIDTH; i++) sq_valid_ff[i] <= 1'b0;
         for (int i = 0; i < QUOT_WIDTH; i++) div_valid_ff[i] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
         sq_valid_ff[0] <= v7_ff;
         for (int i = 1; i < ROOT_WIDTH; i++) sq_valid_ff[i] <= sq_valid_ff[i-1];
         v40_ff <= sq_valid_ff[ROOT_WIDTH-1];
         div_valid_ff[0] <= v40_ff;
         for (int i = 1; i < QUOT_WIDTH; i++) div_valid_ff[i] <= div_valid_ff[i-1];
         v72_ff <= div_valid_ff[QUOT_WIDTH-1];
         v73_ff <= v72_ff; v74_ff <= v73_ff;
         out_valid_ff <= v74_ff;
      end
   end

   // round half up of the forward rotation, then subtract the center
   always_comb begin
      sumx2 = SW1'(pxc_ff) - SW1'(pys_ff) + RND1;
      sumy2 = SW1'(pxs_ff) + SW1'(pyc_ff) + RND1;
      rotx2 = sumx2[SW1-1:ROT_SHIFT];
      roty2 = sumy2[SW1-1:ROT_SHIFT];
   end

   assign magx3 = xx2_ff[XW-1] ? XW'(-xx2_ff) : XW'(xx2_ff);
   assign magy3 = yy2_ff[XW-1] ? XW'(-yy2_ff) : XW'(yy2_ff);

   // position of the leading one of the larger magnitude
   always_comb begin
      max4    = (u3_ff > v3m_ff) ? u3_ff : v3m_ff;
      pos4_in = '0;
      for (int i = 0; i < UW; i++) begin
         if (max4[i]) pos4_in = POSW'(i);
      end
   end

   // common shift that brings the larger magnitude into [2^30, 2^31)
   always_comb begin
      shr5 = pos4_ff - POSW'(NORM_WIDTH - 1);
      shl5 = POSW'(NORM_WIDTH - 1) - pos4_ff;
      if (pos4_ff >= POSW'(NORM_WIDTH - 1)) begin
         un5_in = NORM_WIDTH'(u4_ff >> shr5);
         vn5_in = NORM_WIDTH'(v4m_ff >> shr5);
      end else begin
         un5_in = NORM_WIDTH'(u4_ff << shl5);
         vn5_in = NORM_WIDTH'(v4m_ff << shl5);
      end
   end

   erbp_isqrt u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (rad7_ff),
      .root     (den)
   );

   erbp_div u_div_x (
      .clock       (clock),
      .enable      (adv),
      .numerator   (numx40_ff),
      .denominator (den40_ff),
      .quotient    (rx)
   );

   erbp_div u_div_y (
      .clock       (clock),
      .enable      (adv),
      .numerator   (numy40_ff),
      .denominator (den40_ff),
      .quotient    (ry)
   );

   assign prodx72 = OPW'(axis_a_ff) * OPW'(rx) + RND_OUT;
   assign prody72 = OPW'(axis_b_ff) * OPW'(ry) + RND_OUT;

   // restore signs and add the center back
   always_comb begin
      ofsx73 = side72_ff.neg_x ? -PW2'(ox72_ff) : PW2'(ox72_ff);
      ofsy73 = side72_ff.neg_y ? -PW2'(oy72_ff) : PW2'(oy72_ff);
   end

   // back rotation, round half up, saturate
   always_comb begin
      sumx75 = SS2'(xc74_ff) + SS2'(ys74_ff) + RND2;
      sumy75 = SS2'(yc74_ff) - SS2'(xs74_ff) + RND2;
      rotx75 = sumx75[SS2-1:ROT_SHIFT];
      roty75 = sumy75[SS2-1:ROT_SHIFT];
      if (rotx75 > SAT_HI)      satx75 = SAT_HI[W-1:0];
      else if (rotx75 < SAT_LO) satx75 = SAT_LO[W-1:0];
      else                      satx75 = rotx75[W-1:0];
      if (roty75 > SAT_HI)      saty75 = SAT_HI[W-1:0];
      else if (roty75 < SAT_LO) saty75 = SAT_LO[W-1:0];
      else                      saty75 = roty75[W-1:0];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         pxc_ff <= PW1'(px) * PW1'(cos_ff);
         pys_ff <= PW1'(py) * PW1'(sin_ff);
         pxs_ff <= PW1'(px) * PW1'(sin_ff);
         pyc_ff <= PW1'(py) * PW1'(cos_ff);
         eq1_ff <= (px == cx_ff) && (py == cy_ff);

         xx2_ff <= XW'($signed(rotx2)) - XW'(cx_ff);
         yy2_ff <= XW'($signed(roty2)) - XW'(cy_ff);
         eq2_ff <= eq1_ff;

         u3_ff          <= UW'(axis_b_ff) * UW'(magx3);
         v3m_ff         <= UW'(axis_a_ff) * UW'(magy3);
         side3_ff.invalid <= eq2_ff;
         side3_ff.neg_x <= xx2_ff[XW-1];
         side3_ff.neg_y <= yy2_ff[XW-1];

         u4_ff            <= u3_ff;
         v4m_ff           <= v3m_ff;
         pos4_ff          <= pos4_in;
         side4_ff         <= '{invalid: side3_ff.invalid || (max4 == '0),
                               neg_x:   side3_ff.neg_x,
                               neg_y:   side3_ff.neg_y};

         un5_ff   <= un5_in;
         vn5_ff   <= vn5_in;
         side5_ff <= side4_ff;

         usq6_ff  <= SQ_WIDTH'(un5_ff) * SQ_WIDTH'(un5_ff);
         vsq6_ff  <= SQ_WIDTH'(vn5_ff) * SQ_WIDTH'(vn5_ff);
         un6_ff   <= un5_ff;
         vn6_ff   <= vn5_ff;
         side6_ff <= side5_ff;

         rad7_ff  <= RAD_WIDTH'(usq6_ff) + RAD_WIDTH'(vsq6_ff);
         un7_ff   <= un6_ff;
         vn7_ff   <= vn6_ff;
         side7_ff <= side6_ff;

         // operands ride alongside the square root
         un_sq_ff[0]   <= un7_ff;
         vn_sq_ff[0]   <= vn7_ff;
         side_sq_ff[0] <= side7_ff;
         for (int i = 1; i < ROOT_WIDTH; i++) begin
            un_sq_ff[i]   <= un_sq_ff[i-1];
            vn_sq_ff[i]   <= vn_sq_ff[i-1];
            side_sq_ff[i] <= side_sq_ff[i-1];
         end

         numx40_ff <= NUM_WIDTH'({un_sq_ff[ROOT_WIDTH-1], FRAC_SHIFT'(0)})
                      + NUM_WIDTH'(den >> 1);
         numy40_ff <= NUM_WIDTH'({vn_sq_ff[ROOT_WIDTH-1], FRAC_SHIFT'(0)})
                      + NUM_WIDTH'(den >> 1);
         den40_ff  <= den;
         side40_ff <= side_sq_ff[ROOT_WIDTH-1];

         side_div_ff[0] <= side40_ff;
         for (int i = 1; i < QUOT_WIDTH; i++) side_div_ff[i] <= side_div_ff[i-1];

         ox72_ff   <= prodx72[OPW-1:FRAC_SHIFT];
         oy72_ff   <= prody72[OPW-1:FRAC_SHIFT];
         side72_ff <= side_div_ff[QUOT_WIDTH-1];

         x73_ff   <= ofsx73 + PW2'(cx_ff);
         y73_ff   <= ofsy73 + PW2'(cy_ff);
         inv73_ff <= side72_ff.invalid;

         xc74_ff  <= PP2'(x73_ff) * PP2'(cos_ff);
         ys74_ff  <= PP2'(y73_ff) * PP2'(sin_ff);
         yc74_ff  <= PP2'(y73_ff) * PP2'(cos_ff);
         xs74_ff  <= PP2'(x73_ff) * PP2'(sin_ff);
         inv74_ff <= inv73_ff;

         outx_ff    <= inv74_ff ? '0 : satx75;
         outy_ff    <= inv74_ff ? '0 : saty75;
         out_inv_ff <= inv74_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'({outy_ff, outx_ff});
   assign rsp_tuser  = out_inv_ff;

endmodule

FILE: dv/ellipse_ray_boundary_point_tb.sv
// testbench for the ellipse ray boundary point block: directed and random points
`timescale 1ns / 100ps

module ellipse_ray_boundary_point_tb;
   import erbp_pkg::*;

   localparam int CW         = 24;
   localparam int DW         = 48;
   localparam int LIMIT      = 400000;
   localparam int PIPE_DELAY = 74;     // pipeline latency of the top level

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // point channel, result channel and register port
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata  = '0;     // point_x, point_y
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;           // boundary_x, boundary_y
   logic          rsp_tuser;           // invalid
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [23:0]                csr_wdata = '0;

   // one expected boundary word
   typedef struct packed {
      logic [CW-1:0] bx;
      logic [CW-1:0] by;
      logic          inv;
   } boundary_word;

   boundary_word boundary_q[$];

   // shadow copy of the geometry registers
   logic signed [15:0]   cos_q, sin_q;
   logic [23:0]          axis_a, axis_b;
   logic signed [CW-1:0] ctr_x, ctr_y;

   int mismatches = 0;
   int cycles     = 0;
   int send_idle  = 0;   // percent of cycles the sender holds back
   int recv_idle  = 0;   // percent of cycles the receiver holds back
   bit hold_req   = 0;   // ask the receiver for a long hold-off
   int hold_count = 0;

   ellipse_ray_boundary_point #(.COORD_WIDTH(CW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls, plus a counted long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_count = 400;
         hold_req   = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // integer square root, bit by bit
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res, bt;
      res = 0;
      bt  = 64'h4000_0000_0000_0000;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n   = n - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   // round half up from q.22 to q.8
   function automatic longint round14(input longint v);
      return (v + 64'sd8192) >>> 14;
   endfunction

   function automatic logic [CW-1:0] clamp_coord(input longint v);
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      return v[CW-1:0];
   endfunction

   // expected boundary point for one query point under the shadow geometry
   function automatic boundary_word boundary_of(input logic signed [CW-1:0] px_i,
                                                input logic signed [CW-1:0] py_i);
      boundary_word w;
      longint px, py, c, s, cx, cy, xx, yy, x, y;
      longint unsigned a, b, u, v, m, den, rx, ry, ox, oy;
      px = px_i;  py = py_i;  c = cos_q;  s = sin_q;  cx = ctr_x;  cy = ctr_y;
      a  = axis_a;  b = axis_b;
      w  = '{bx: '0, by: '0, inv: 1'b1};
      if (px_i == ctr_x && py_i == ctr_y) return w;
      // into the ellipse frame
      xx = round14(px * c - py * s) - cx;
      yy = round14(px * s + py * c) - cy;
      u = b * longint'(xx < 0 ? -xx : xx);
      v = a * longint'(yy < 0 ? -yy : yy);
      m = (u > v) ? u : v;
      if (m == 0) return w;
      // normalize the larger magnitude into [2^30, 2^31)
      while (m >= 64'd2147483648) begin u >>= 1; v >>= 1; m >>= 1; end
      while (m < 64'd1073741824) begin u <<= 1; v <<= 1; m <<= 1; end
      den = root_floor(u * u + v * v);
      rx  = ((u << 30) + (den >> 1)) / den;
      ry  = ((v << 30) + (den >> 1)) / den;
      ox  = (a * rx + 64'd536870912) >> 30;
      oy  = (b * ry + 64'd536870912) >> 30;
      x = (xx < 0 ? -longint'(ox) : longint'(ox)) + cx;
      y = (yy < 0 ? -longint'(oy) : longint'(oy)) + cy;
      // back out of the ellipse frame
      w.bx  = clamp_coord(round14(x * c + y * s));
      w.by  = clamp_coord(round14(y * c - x * s));
      w.inv = 1'b0;
      return w;
   endfunction

   // result checker
   always @(posedge clock) begin
      boundary_word got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{bx: rsp_tdata[CW-1:0], by: rsp_tdata[2*CW-1:CW], inv: rsp_tuser};
         if (boundary_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: got %h", got);
         end else begin
            want = boundary_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: x exp %h got %h, y exp %h got %h, inv exp %b got %b",
                           want.bx, got.bx, want.by, got.by, want.inv, got.inv);
            end
         end
      end
   end

   // register write: enable stays high until geometry_done lowers it
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_COS_THETA:   cos_q  = val[15:0];
         REG_SIN_THETA:   sin_q  = val[15:0];
         REG_SEMI_AXIS_X: axis_a = val;
         REG_SEMI_AXIS_Y: axis_b = val;
         REG_CENTER_X:    ctr_x  = val;
         REG_CENTER_Y:    ctr_y  = val;
         default: ;       // out-of-range index is ignored
      endcase
   endtask

   task automatic geometry_done();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_geometry(input int c, input int s, input int a, input int b,
                                input int cx, input int cy);
      write_reg(REG_COS_THETA, 24'(c));
      write_reg(REG_SIN_THETA, 24'(s));
      write_reg(REG_SEMI_AXIS_X, 24'(a));
      write_reg(REG_SEMI_AXIS_Y, 24'(b));
      write_reg(REG_CENTER_X, 24'(cx));
      write_reg(REG_CENTER_Y, 24'(cy));
      geometry_done();
   endtask

   // one point word; valid stays high between back-to-back words
   task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      do @(posedge clock); while (!req_tready);
      boundary_q = {boundary_q, boundary_of(px, py)};
   endtask

   // wait for every word to come back, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (boundary_q.size() != 0) @(posedge clock);
      repeat (PIPE_DELAY + 20) @(posedge clock);
   endtask

   task automatic random_geometry();
      int c, s, a, b, cx, cy;
      case ($urandom_range(5))
         0: begin c = 16384; s = 0; end
         1: begin c = -16384; s = 16384; end
         2: begin c = 11585; s = -11585; end
         default: begin
            c = int'($urandom_range(32768)) - 16384;
            s = int'($urandom_range(32768)) - 16384;
         end
      endcase
      if ($urandom_range(3) == 0) begin
         a = $urandom_range(24'hFFFFFF);
         b = $urandom_range(24'hFFFFFF);
      end else begin
         a = $urandom_range(1 << 18);
         b = $urandom_range(1 << 18);
      end
      cx = int'($urandom_range(1 << 20)) - (1 << 19);
      cy = int'($urandom_range(1 << 20)) - (1 << 19);
      if ($urandom_range(7) == 0) begin
         cx = $urandom; cy = $urandom;  // full-range centers, truncated to 24 bits
      end
      load_geometry(c, s, a, b, cx, cy);
   endtask

   // mostly points near the center, some anywhere, a few exactly on it
   task automatic random_points(input int n);
      int k;
      logic [CW-1:0] px, py;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(19))
            0: begin px = ctr_x; py = ctr_y; end
            1, 2, 3, 4: begin px = $urandom; py = $urandom; end
            default: begin
               px = ctr_x + CW'(int'($urandom_range(1 << 16)) - (1 << 15));
               py = ctr_y + CW'(int'($urandom_range(1 << 16)) - (1 << 15));
            end
         endcase
         send_point(px, py);
      end
   endtask

   task automatic test_reset_geometry();
      send_point(24'h000100, 24'h000000);
      send_point(24'h000000, 24'hFFFF00);
      send_point(24'h001234, 24'hFF8765);
      send_point(24'h000000, 24'h000000);   // point at center
      drain();
   endtask

   task automatic test_extremes();
      load_geometry(16384, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
      send_point(24'h7FFFFF, 24'h7FFFFF);
      send_point(24'h800000, 24'h800000);
      send_point(24'h7FFFFF, 24'h800000);
      send_point(24'h000001, 24'h000000);
      drain();
      load_geometry(-16384, 16384, 24'hFFFFFF, 1, 24'h7FFFFF, 24'h800000);
      send_point(24'h800000, 24'h7FFFFF);
      send_point(24'h000000, 24'h000000);
      send_point(24'h7FFFFF, 24'h800000);   // point at center
      drain();
      // rotation pair that is not a unit vector, raw patterns outside q1.14
      load_geometry(16'h8000, 16'h7FFF, 300, 700, -1000, 2000);
      send_point(24'h001000, 24'hFFF000);
      send_point(24'h7FFFFF, 24'h000001);
      drain();
   endtask

   task automatic test_special_cases();
      // both axes zero: zero denominator everywhere
      load_geometry(16384, 0, 0, 0, 500, 500);
      send_point(24'h001000, 24'h002000);
      send_point(24'h000000, 24'h000000);
      drain();
      // one axis zero: offset along the other axis only gives zero denominator
      load_geometry(16384, 0, 0, 512, 0, 0);
      send_point(24'h000000, 24'h000400);
      send_point(24'h000400, 24'h000400);
      drain();
      // zero rotation squashes every point onto the origin
      load_geometry(0, 0, 256, 256, 0, 0);
      send_point(24'h010000, 24'h020000);
      drain();
      // indexes past the last register must not disturb the geometry
      write_reg(3'd6, 24'hABCDEF);
      write_reg(3'd7, 24'h123456);
      geometry_done();
      send_point(24'h000100, 24'h000100);
      drain();
   endtask

   task automatic test_random_phase(input int snd, input int rcv, input int sets,
                                    input int per_set);
      int k;
      send_idle = snd;
      recv_idle = rcv;
      for (k = 0; k < sets; k++) begin
         random_geometry();
         random_points(per_set);
         drain();
      end
   endtask

   task automatic test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      random_geometry();
      hold_req = 1;     // receiver stops while points keep coming, so the pipe fills
      random_points(250);
      drain();
   endtask

   initial begin
      cos_q  = COS_RESET;
      sin_q  = SIN_RESET;
      axis_a = AXIS_RESET;
      axis_b = AXIS_RESET;
      ctr_x  = '0;
      ctr_y  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 17;
      recv_idle = 74;
      test_reset_geometry();
      test_extremes();
      test_special_cases();
      test_random_phase(17, 74, 3, 120);
      test_random_phase(74, 17, 3, 120);
      test_random_phase(0, 0, 3, 50);
      test_backpressure();

      if (mismatches == 0 && boundary_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/erbp_pkg.sv
rtl/erbp_isqrt.sv
rtl/erbp_div.sv
rtl/ellipse_ray_boundary_point.sv
dv/ellipse_ray_boundary_point_tb.sv
